[hw/rtl/canfd_tx_frame_ring_allocator_core_assert.svh]
// Assertion macros shared by the checker of the transmit ring allocator.
// Depends on nothing; included by the files that hold assertions.
`ifndef CANFD_TX_FRAME_RING_ALLOCATOR_CORE_ASSERT_SVH
`define CANFD_TX_FRAME_RING_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFTX_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("cftx assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFTX_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("cftx assertion failed");

`endif

[hw/rtl/cftx_pkg.sv]
// Shared types, codes and length tables of the CAN FD transmit ring allocator.
// Depends on nothing; imported by the header formatter, the core and the checker.
`default_nettype none

package cftx_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;

	localparam logic [1:0] CMD_SUBMIT = 2'd0;
	localparam logic [1:0] CMD_DONE = 2'd1;
	localparam logic [1:0] CMD_REMOTE = 2'd2;

	localparam logic [1:0] FMT_AUTO = 2'd0;
	localparam logic [1:0] FMT_CLASSIC = 2'd1;
	localparam logic [1:0] FMT_FD = 2'd2;

	localparam logic REG_FD_ENABLED = 1'b0;

	localparam logic [28:0] STD_ID_MAX = 29'h7FF;
	localparam logic [6:0] CLASSIC_MAX = 7'd8;
	localparam logic [6:0] MAX_LEN = 7'd64;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} st_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [28:0] frame_id;
		logic want_extended;
		logic [1:0] frame_format;
		logic brs_request;
		logic [6:0] payload_len;
		logic [3:0] remote_dlc;
	} req_t;

	typedef struct packed {
		logic fdf;
		logic brs;
		logic [3:0] dlc;
		logic [6:0] frame_len;
		logic [3:0] pad_bytes;
		logic [6:0] fp_base;
	} hdr_t;

	// Smallest FD DLC whose length covers len (len at most 64).
	function automatic logic [3:0] len_to_dlc(input logic [6:0] len);
		logic [3:0] d;
		if (len <= 7'd8) d = len[3:0];
		else if (len <= 7'd12) d = 4'd9;
		else if (len <= 7'd16) d = 4'd10;
		else if (len <= 7'd20) d = 4'd11;
		else if (len <= 7'd24) d = 4'd12;
		else if (len <= 7'd32) d = 4'd13;
		else if (len <= 7'd48) d = 4'd14;
		else d = 4'd15;
		return d;
	endfunction

	function automatic logic [6:0] dlc_to_len(input logic [3:0] dlc);
		logic [6:0] l;
		case (dlc)
			4'd9: l = 7'd12;
			4'd10: l = 7'd16;
			4'd11: l = 7'd20;
			4'd12: l = 7'd24;
			4'd13: l = 7'd32;
			4'd14: l = 7'd48;
			4'd15: l = 7'd64;
			default: l = {3'b000, dlc};
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/cftx_hdr_fmt.sv]
// Header formatter: frame format, bit rate switch, DLC, padded length and
// the 4-byte-rounded base footprint of a data frame. Depends on cftx_pkg.
`default_nettype none

module cftx_hdr_fmt (
	input wire logic fd_enabled,
	input wire logic [1:0] frame_format,
	input wire logic brs_request,
	input wire logic [6:0] payload_len,
	output cftx_pkg::hdr_t hdr
);
	import cftx_pkg::*;

	logic [6:0] len_sat;
	logic use_fd;
	logic [3:0] fd_dlc;
	logic [6:0] fd_len;
	logic [6:0] flen;

	always_comb begin
		len_sat = (payload_len > MAX_LEN) ? MAX_LEN : payload_len;
		use_fd = fd_enabled &&
			((frame_format == FMT_FD) || ((frame_format == FMT_AUTO) && (len_sat > CLASSIC_MAX)));
		fd_dlc = len_to_dlc(len_sat);
		fd_len = dlc_to_len(fd_dlc);
		hdr = '0;
		if (use_fd) begin
			hdr.fdf = 1'b1;
			hdr.brs = brs_request;
			hdr.dlc = fd_dlc;
			flen = fd_len;
			hdr.pad_bytes = 4'(fd_len - len_sat);
		end else begin
			// Classic frames are cut to eight bytes and never padded.
			flen = (len_sat > CLASSIC_MAX) ? CLASSIC_MAX : len_sat;
			hdr.dlc = flen[3:0];
		end
		hdr.frame_len = flen;
		hdr.fp_base = (flen + 7'd3) & ~7'd3;
	end

endmodule

`default_nettype wire

[hw/rtl/cftx_fp_ram.sv]
// Footprint queue storage: one write port and one read port with the
// read data registered. Depends on nothing.
`default_nettype none

module cftx_fp_ram #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [6:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [6:0] rdata
);

	logic [6:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/canfd_tx_frame_ring_allocator_core.sv]
// CAN FD transmit header formatter and ring space manager.
// Requests enter on the s_ stream (cmd in s_tuser, the rest in s_tdata);
// every request gives exactly one result on the m_ stream.
// A submit builds the frame header and reserves a footprint at the ring
// head, wrapping the head to zero when less than one maximal frame would
// remain; a transmit-done frees the oldest queued footprint; a remote
// request queues a zero footprint. Refused requests report accepted = 0.
// fd_enabled is written over the APB port at byte address 0.
// Timing: a request is taken in idle and executed in the execution state,
// which waits for a free output register; no new request is taken before
// the last one executes. A transmit-done uses the footprint memory read
// registered on intake; the result is in m_tdata the cycle after execution.
// A stalled result is held in the output register; one further request
// may be taken meanwhile, and it waits in execution until the output
// register is free, with s_tready low.
// Reset clears the ring head, the used count, the queue pointers, the
// level and fd_enabled; the queue memory needs no clearing.
`default_nettype none

module canfd_tx_frame_ring_allocator_core #(
	parameter int RING_BYTES = 1024,
	parameter int FIFO_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	// s_tdata, lowest bit up: frame_id[28:0], want_extended, frame_format[1:0],
	// brs_request, payload_len[6:0], remote_dlc[3:0], zero fill
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [cftx_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: cmd[1:0]
	input wire logic [cftx_pkg::S_TUSER_W-1:0] s_tuser,
	// m_tdata, lowest bit up: accepted, ide, fdf, brs, rtr, dlc[3:0],
	// frame_len[6:0], pad_bytes[3:0], buffer_offset[9:0], footprint[6:0],
	// used_bytes[10:0], space_ready, zero fill
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [cftx_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cftx_pkg::*;

	localparam int HW = $clog2(RING_BYTES);
	localparam int UW = $clog2(RING_BYTES + 1);
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int LW = $clog2(FIFO_DEPTH + 1);
	localparam logic [UW-1:0] USED_LIMIT = UW'(RING_BYTES - MAX_FRAME_BYTES);
	localparam logic [UW-1:0] RING_U = UW'(RING_BYTES);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [LW-1:0] LEVEL_FULL = LW'(FIFO_DEPTH);

	st_t state_q, state_d;
	req_t req_s1;
	logic fd_enabled_q;
	logic [HW-1:0] head_q;
	logic [UW-1:0] used_q;
	logic [PW-1:0] rd_ptr_q, wr_ptr_q;
	logic [LW-1:0] level_q;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic in_fire, exec_fire;
	hdr_t hdr;
	logic [6:0] ram_rdata;

	logic acc, ide, push, pop;
	logic [6:0] fp;
	logic [UW-1:0] next_sum, gap;
	logic [HW-1:0] head_d;
	logic [UW-1:0] used_d;
	logic [M_TDATA_W-1:0] res_word;
	logic [31:0] used_ext, off_ext;
	logic [9:0] res_off;
	logic res_ide, res_fdf, res_brs, res_rtr;
	logic [3:0] res_dlc, res_pad;
	logic [6:0] res_len;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FD_ENABLED) ? {31'd0, fd_enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_enabled_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FD_ENABLED)) begin
			fd_enabled_q <= pwdata[0];
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!m_tvalid_q || m_tready) begin
					exec_fire = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1.cmd <= s_tuser;
			req_s1.frame_id <= s_tdata[28:0];
			req_s1.want_extended <= s_tdata[29];
			req_s1.frame_format <= s_tdata[31:30];
			req_s1.brs_request <= s_tdata[32];
			req_s1.payload_len <= s_tdata[39:33];
			req_s1.remote_dlc <= s_tdata[43:40];
		end
	end

	cftx_hdr_fmt u_hdr (
		.fd_enabled(fd_enabled_q),
		.frame_format(req_s1.frame_format),
		.brs_request(req_s1.brs_request),
		.payload_len(req_s1.payload_len),
		.hdr(hdr)
	);

	// The oldest footprint is fetched while the request is taken, so it is
	// ready when the request executes. Writes happen only in execution,
	// never in the cycle of a read, and the read pointer is already current.
	cftx_fp_ram #(
		.DEPTH(FIFO_DEPTH),
		.AW(PW)
	) u_ram (
		.clk(clk),
		.we(exec_fire && push),
		.waddr(wr_ptr_q),
		.wdata(fp),
		.re(in_fire),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		acc = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		fp = '0;
		head_d = head_q;
		used_d = used_q;
		res_ide = 1'b0;
		res_fdf = 1'b0;
		res_brs = 1'b0;
		res_rtr = 1'b0;
		res_dlc = '0;
		res_len = '0;
		res_pad = '0;
		res_off = '0;
		ide = (req_s1.frame_id > STD_ID_MAX) ? 1'b1 : req_s1.want_extended;
		next_sum = UW'(head_q) + UW'(hdr.fp_base);
		gap = (next_sum < RING_U) ? (RING_U - next_sum) : '0;
		off_ext = 32'(head_q);
		case (req_s1.cmd)
			CMD_SUBMIT: begin
				if ((used_q <= USED_LIMIT) && (level_q != LEVEL_FULL)) begin
					acc = 1'b1;
					push = 1'b1;
					res_ide = ide;
					res_fdf = hdr.fdf;
					res_brs = hdr.brs;
					res_dlc = hdr.dlc;
					res_len = hdr.frame_len;
					res_pad = hdr.pad_bytes;
					res_off = off_ext[9:0];
					// Too little room behind the new head: the tail gap is
					// charged to this frame and the head wraps.
					if (next_sum > USED_LIMIT) begin
						fp = hdr.fp_base + 7'(gap);
						head_d = '0;
					end else begin
						fp = hdr.fp_base;
						head_d = HW'(next_sum);
					end
					used_d = used_q + UW'(fp);
				end
			end
			CMD_DONE: begin
				if (level_q != '0) begin
					acc = 1'b1;
					pop = 1'b1;
					fp = ram_rdata;
					used_d = (UW'(ram_rdata) > used_q) ? '0 : used_q - UW'(ram_rdata);
				end
			end
			CMD_REMOTE: begin
				if (level_q != LEVEL_FULL) begin
					acc = 1'b1;
					push = 1'b1;
					res_ide = ide;
					res_rtr = 1'b1;
					res_dlc = (req_s1.remote_dlc > 4'd8) ? 4'd8 : req_s1.remote_dlc;
				end
			end
			default: acc = 1'b0;
		endcase
		used_ext = 32'(used_d);
		res_word = {7'd0, (used_d <= USED_LIMIT), used_ext[10:0], fp, res_off, res_pad,
			res_len, res_dlc, res_rtr, res_brs, res_fdf, res_ide, acc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			used_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q <= '0;
		end else if (exec_fire) begin
			head_q <= head_d;
			used_q <= used_d;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				level_q <= level_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (exec_fire) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_fire) m_tdata_q <= res_word;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

[hw/rtl/cftx_checker.sv]
// Port-level checks of the transmit ring allocator, bound to the top level.
// Depends on cftx_pkg and the assertion macro header.
`default_nettype none
`include "canfd_tx_frame_ring_allocator_core_assert.svh"

module cftx_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [cftx_pkg::M_TDATA_W-1:0] m_tdata
);
	import cftx_pkg::*;

	// A held result must not change while the receiver stalls.
	`CFTX_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Requests are handled one at a time: no request is taken right after one.
	`CFTX_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// A refused request carries nothing but the ring occupancy.
	`CFTX_ASSERT_NOW(a_refused_clean, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[36:1] == 36'd0)
	// A remote frame is classic and takes no ring bytes.
	`CFTX_ASSERT_NOW(a_remote_empty, clk, arst_n, m_tvalid && m_tdata[4],
		(m_tdata[2] == 1'b0) && (m_tdata[15:9] == 7'd0) && (m_tdata[36:30] == 7'd0))

endmodule

bind canfd_tx_frame_ring_allocator_core cftx_checker u_cftx_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

`default_nettype wire
